// ----- design/source_text_lexer_macros.svh -----
// Assertion macros for the source text lexer checker.
`ifndef SOURCE_TEXT_LEXER_MACROS_SVH
`define SOURCE_TEXT_LEXER_MACROS_SVH
`define STL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STL_ASSERT_NORST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- design/stl_pkg.sv -----
// Shared types and constants for the source text lexer.
`default_nettype none
package stl_pkg;
    localparam logic [4:0] K_EOF = 5'd0;
    localparam logic [4:0] K_MINUS = 5'd1;
    localparam logic [4:0] K_PLUS = 5'd2;
    localparam logic [4:0] K_TIMES = 5'd3;
    localparam logic [4:0] K_DIV = 5'd4;
    localparam logic [4:0] K_LPAREN = 5'd5;
    localparam logic [4:0] K_RPAREN = 5'd6;
    localparam logic [4:0] K_LCURLY = 5'd7;
    localparam logic [4:0] K_RCURLY = 5'd8;
    localparam logic [4:0] K_SEMI = 5'd9;
    localparam logic [4:0] K_COMMA = 5'd10;
    localparam logic [4:0] K_EQ = 5'd11;
    localparam logic [4:0] K_NE = 5'd12;
    localparam logic [4:0] K_LE = 5'd13;
    localparam logic [4:0] K_GE = 5'd14;
    localparam logic [4:0] K_LT = 5'd15;
    localparam logic [4:0] K_GT = 5'd16;
    localparam logic [4:0] K_ASSIGN = 5'd17;
    localparam logic [4:0] K_INT = 5'd18;
    localparam logic [4:0] K_FLOAT = 5'd19;
    localparam logic [4:0] K_RETURN = 5'd20;
    localparam logic [4:0] K_TYPE = 5'd21;
    localparam logic [4:0] K_IDENT = 5'd22;
    localparam logic [4:0] K_ERROR = 5'd23;

    localparam logic [1:0] R_DEC = 2'd0;
    localparam logic [1:0] R_OCT = 2'd1;
    localparam logic [1:0] R_HEX = 2'd2;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [7:0] FCNT_MAX = 8'd255;

    typedef enum logic [8:0] {
        M_IDLE  = 9'b000000001,
        M_SLASH = 9'b000000010,
        M_LINE  = 9'b000000100,
        M_BLOCK = 9'b000001000,
        M_BSTAR = 9'b000010000,
        M_CMP   = 9'b000100000,
        M_NUM   = 9'b001000000,
        M_FRAC  = 9'b010000000,
        M_WORD  = 9'b100000000
    } lex_mode_t;

    // keyword spelling, one byte per letter position
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
        logic [47:0] s;
        begin
            unique case (k)
                2'd0: s = "return";
                2'd1: s = {"void", 16'h0};
                2'd2: s = {"int", 24'h0};
                default: s = {"float", 8'h0};
            endcase
            kw_char = (i < 3'd6) ? s[47 - 8*i -: 8] : 8'h0;
        end
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        unique case (k)
            2'd0: kw_len = 3'd6;
            2'd1: kw_len = 3'd4;
            2'd2: kw_len = 3'd3;
            default: kw_len = 3'd5;
        endcase
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
endpackage
`default_nettype wire

// ----- design/stl_front.sv -----
// Lexer front: per-byte mode tracking and token building.
`default_nettype none
module stl_front
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [7:0]             c,
    input  wire logic                   last,
    output logic [2:0]                  n_tok,
    output logic [2:0][4:0]             t_kind,
    output logic [2:0][1:0]             t_type,
    output logic [2:0][VALUE_BITS-1:0]  t_iv,
    output logic [2:0][VALUE_BITS-1:0]  t_fv,
    output logic [2:0][7:0]             t_fd,
    output logic [2:0][OFFSET_BITS-1:0] t_start,
    output logic [2:0][15:0]            t_len
);
    lex_mode_t mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, tstart_reg, tstart_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next, facc_reg, facc_next;
    logic [7:0] fcnt_reg, fcnt_next, pend_reg, pend_next;
    logic [1:0] radix_reg, radix_next;
    logic [3:0] cand_reg, cand_next;
    logic [15:0] len_reg, len_next;
    logic err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg <= '0;
            tstart_reg <= '0;
            acc_reg <= '0;
            facc_reg <= '0;
            fcnt_reg <= '0;
            radix_reg <= R_DEC;
            cand_reg <= 4'hF;
            len_reg <= '0;
            pend_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            tstart_reg <= tstart_next;
            acc_reg <= acc_next;
            facc_reg <= facc_next;
            fcnt_reg <= fcnt_next;
            radix_reg <= radix_next;
            cand_reg <= cand_next;
            len_reg <= len_next;
            pend_reg <= pend_next;
            err_reg <= err_next;
        end
    end

    logic [15:0] len_inc;
    logic [4:0] dig;
    logic [4:0] base;
    logic [4:0] op_kind;
    logic [3:0] nc;
    logic [2:0] cur_len;
    logic kw_hit;
    logic [1:0] kw_idx;
    logic do_begin, do_flush, word_step;

    assign len_inc = (len_reg < LEN_MAX) ? len_reg + 16'd1 : len_reg;

    always_comb
    begin
        if (c >= "0" && c <= "9") dig = 5'(c - "0");
        else if (c >= "a" && c <= "f") dig = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") dig = 5'(c - "A" + 8'd10);
        else dig = 5'd16;
        base = (radix_reg == R_HEX) ? 5'd16 : (radix_reg == R_OCT) ? 5'd8 : 5'd10;
        op_kind = (c == "-") ? K_MINUS : (c == "+") ? K_PLUS : (c == "*") ? K_TIMES :
                  (c == "(") ? K_LPAREN : (c == ")") ? K_RPAREN : (c == "{") ? K_LCURLY :
                  (c == "}") ? K_RCURLY : (c == ";") ? K_SEMI : (c == ",") ? K_COMMA : K_EOF;
    end

    // one token push; slot order preserved
    task automatic push(inout logic [2:0] n, input logic [4:0] k, input logic [1:0] ty,
                        input logic [VALUE_BITS-1:0] iv, input logic [VALUE_BITS-1:0] fv,
                        input logic [7:0] fd, input logic [OFFSET_BITS-1:0] st,
                        input logic [15:0] ln);
        begin
            if (n < 3'd3)
            begin
                t_kind[n[1:0]] = k;
                t_type[n[1:0]] = ty;
                t_iv[n[1:0]] = iv;
                t_fv[n[1:0]] = fv;
                t_fd[n[1:0]] = fd;
                t_start[n[1:0]] = st;
                t_len[n[1:0]] = ln;
                n = n + 3'd1;
            end
        end
    endtask

    always_comb
    begin
        logic [2:0] n;
        logic [4:0] ck;
        logic [15:0] wl;
        lex_mode_t fm;
        n = '0;
        ck = '0;
        wl = '0;
        t_kind = '0; t_type = '0; t_iv = '0; t_fv = '0; t_fd = '0;
        t_start = '0; t_len = '0;
        mode_next = mode_reg;
        pos_next = pos_reg + OFFSET_BITS'(1);
        tstart_next = tstart_reg;
        acc_next = acc_reg;
        facc_next = facc_reg;
        fcnt_next = fcnt_reg;
        radix_next = radix_reg;
        cand_next = cand_reg;
        len_next = len_reg;
        pend_next = pend_reg;
        err_next = err_reg;
        do_begin = 1'b0;
        do_flush = 1'b0;
        word_step = 1'b0;
        nc = '0; cur_len = '0; kw_hit = 1'b0; kw_idx = '0;
        fm = mode_reg;

        if (!err_reg)
        begin
            unique case (mode_reg)
                M_SLASH:
                    if (c == "/") mode_next = M_LINE;
                    else if (c == "*") mode_next = M_BSTAR;
                    else begin do_flush = 1'b1; do_begin = 1'b1; end
                M_LINE:  if (c == 8'h0A) mode_next = M_IDLE;
                M_BLOCK: if (c == "*") mode_next = M_BSTAR;
                M_BSTAR:
                    if (c == "/") mode_next = M_IDLE;
                    else if (c != "*") mode_next = M_BLOCK;
                M_CMP:
                    if (c == "=")
                    begin
                        ck = (pend_reg == "=") ? K_EQ : (pend_reg == "!") ? K_NE :
                             (pend_reg == "<") ? K_LE : K_GE;
                        push(n, ck, 2'd0, '0, '0, '0, tstart_reg, 16'd2);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_begin = (pend_reg != "!");
                    end
                M_NUM:
                    if (radix_reg == R_OCT && len_reg == 16'd1 && acc_reg == '0 &&
                        (c == "x" || c == "X"))
                    begin
                        radix_next = R_HEX;
                        len_next = len_inc;
                    end
                    else if (dig < base)
                    begin
                        acc_next = VALUE_BITS'(acc_reg * VALUE_BITS'(base)) +
                                   VALUE_BITS'(dig);
                        len_next = len_inc;
                    end
                    else if (c == ".")
                    begin
                        mode_next = M_FRAC;
                        len_next = len_inc;
                    end
                    else begin do_flush = 1'b1; do_begin = 1'b1; end
                M_FRAC:
                    if (c >= "0" && c <= "9")
                    begin
                        facc_next = VALUE_BITS'(facc_reg * VALUE_BITS'(10)) +
                                    VALUE_BITS'(c - "0");
                        if (fcnt_reg < FCNT_MAX) fcnt_next = fcnt_reg + 8'd1;
                        len_next = len_inc;
                    end
                    else begin do_flush = 1'b1; do_begin = 1'b1; end
                M_WORD:
                    if (is_letter(c)) word_step = 1'b1;
                    else begin do_flush = 1'b1; do_begin = 1'b1; end
                default: do_begin = 1'b1;
            endcase

            // close the open token
            if (do_flush)
            begin
                unique case (mode_reg)
                    M_SLASH: push(n, K_DIV, 2'd0, '0, '0, '0, tstart_reg, 16'd1);
                    M_CMP:
                    begin
                        ck = (pend_reg == "<") ? K_LT : (pend_reg == ">") ? K_GT :
                             (pend_reg == "=") ? K_ASSIGN : K_ERROR;
                        if (ck == K_ERROR) err_next = 1'b1;
                        push(n, ck, 2'd0, '0, '0, '0, tstart_reg, 16'd1);
                    end
                    M_NUM: push(n, K_INT, 2'd0, acc_reg, '0, '0, tstart_reg, len_reg);
                    M_FRAC: push(n, K_FLOAT, 2'd0, acc_reg, facc_reg, fcnt_reg,
                                 tstart_reg, len_reg);
                    M_WORD: push(n, K_IDENT, 2'd0, '0, '0, '0, tstart_reg, len_reg);
                    default: ;
                endcase
                mode_next = M_IDLE;
            end

            if (do_begin)
            begin
                if (c == " " || (c >= 8'd9 && c <= 8'd13)) ;
                else if (op_kind != K_EOF)
                    push(n, op_kind, 2'd0, '0, '0, '0, pos_reg, 16'd1);
                else
                begin
                    tstart_next = pos_reg;
                    if (c == "/") mode_next = M_SLASH;
                    else if (c == "=" || c == "!" || c == "<" || c == ">")
                    begin
                        mode_next = M_CMP;
                        pend_next = c;
                    end
                    else if (c >= "0" && c <= "9")
                    begin
                        mode_next = M_NUM;
                        len_next = 16'd1;
                        acc_next = VALUE_BITS'(c - "0");
                        facc_next = '0;
                        fcnt_next = '0;
                        radix_next = (c == "0") ? R_OCT : R_DEC;
                    end
                    else if (is_letter(c))
                    begin
                        mode_next = M_WORD;
                        word_step = 1'b1;
                    end
                    else
                    begin
                        push(n, K_ERROR, 2'd0, '0, '0, '0, pos_reg, 16'd1);
                        err_next = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
            end

            // keyword candidate tracking for a word letter
            if (word_step)
            begin
                wl = (mode_reg == M_WORD) ? len_reg : 16'd0;
                cand_next = (mode_reg == M_WORD) ? cand_reg : 4'hF;
                if (cand_next != 4'h0)
                begin
                    for (int k = 0; k < 4; k++)
                        if (cand_next[k] && wl < 16'(kw_len(2'(k))) &&
                            kw_char(2'(k), wl[2:0]) == c)
                            nc[k] = 1'b1;
                    if (nc != 4'h0)
                    begin
                        cur_len = wl[2:0] + 3'd1;
                        len_next = 16'(cur_len);
                        for (int k = 3; k >= 0; k--)
                            if (nc[k] && kw_len(2'(k)) == cur_len)
                            begin
                                kw_hit = 1'b1;
                                kw_idx = 2'(k);
                            end
                        if (kw_hit)
                        begin
                            push(n, (kw_idx == 2'd0) ? K_RETURN : K_TYPE,
                                 (kw_idx == 2'd0) ? 2'd0 : kw_idx - 2'd1,
                                 '0, '0, '0, tstart_next, 16'(kw_len(kw_idx)));
                            mode_next = M_IDLE;
                            cand_next = 4'h0;
                        end
                        else cand_next = nc;
                    end
                    else
                    begin
                        cand_next = 4'h0;
                        len_next = (wl < LEN_MAX) ? wl + 16'd1 : wl;
                    end
                end
                else len_next = (wl < LEN_MAX) ? wl + 16'd1 : wl;
            end
        end

        if (last)
        begin
            if (!err_next)
            begin
                fm = mode_next;
                unique case (fm)
                    M_SLASH: push(n, K_DIV, 2'd0, '0, '0, '0, tstart_next, 16'd1);
                    M_CMP:
                    begin
                        ck = (pend_next == "<") ? K_LT : (pend_next == ">") ? K_GT :
                             (pend_next == "=") ? K_ASSIGN : K_ERROR;
                        push(n, ck, 2'd0, '0, '0, '0, tstart_next, 16'd1);
                    end
                    M_NUM: push(n, K_INT, 2'd0, acc_next, '0, '0, tstart_next, len_next);
                    M_FRAC: push(n, K_FLOAT, 2'd0, acc_next, facc_next, fcnt_next,
                                 tstart_next, len_next);
                    M_WORD: push(n, K_IDENT, 2'd0, '0, '0, '0, tstart_next, len_next);
                    default: ;
                endcase
            end
            push(n, K_EOF, 2'd0, '0, '0, '0, pos_reg + OFFSET_BITS'(1), 16'd0);
            mode_next = M_IDLE;
            pos_next = '0;
            tstart_next = '0;
            acc_next = '0;
            facc_next = '0;
            fcnt_next = '0;
            radix_next = R_DEC;
            cand_next = 4'hF;
            len_next = '0;
            pend_next = '0;
            err_next = 1'b0;
        end
        n_tok = n;
    end
endmodule
`default_nettype wire

// ----- design/stl_queue.sv -----
// Token group queue between lexer front and output drain.
`default_nettype none
module stl_queue
#(
    parameter int W = 8,
    parameter int DEPTH_LOG = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic              nonempty,
    output logic [W-1:0]      rdata
);
    localparam int DEPTH = 1 << DEPTH_LOG;
    logic [W-1:0] mem [DEPTH];
    logic [DEPTH_LOG:0] wp_reg, rp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wp_reg[DEPTH_LOG-1:0]] <= wdata;
    end

    assign nonempty = (wp_reg != rp_reg);
    assign full = (wp_reg[DEPTH_LOG] != rp_reg[DEPTH_LOG]) &&
                  (wp_reg[DEPTH_LOG-1:0] == rp_reg[DEPTH_LOG-1:0]);
    assign rdata = mem[rp_reg[DEPTH_LOG-1:0]];
endmodule
`default_nettype wire

// ----- design/stl_back.sv -----
// Output drain: emits the tokens of one queued group one per cycle, stalling while ready is low.
`default_nettype none
module stl_back
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int VALUE_BITS = 32,
    parameter int TW = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   nonempty,
    input  wire logic [2:0]             g_n,
    input  wire logic [3*TW-1:0]        g_tok,
    output logic                        pop,
    output logic                        valid,
    input  wire logic                   ready,
    output logic [4:0]                  token_kind,
    output logic [1:0]                  type_code,
    output logic [VALUE_BITS-1:0]       int_value,
    output logic [VALUE_BITS-1:0]       fraction_value,
    output logic [7:0]                  fraction_digits,
    output logic [OFFSET_BITS-1:0]      start_offset,
    output logic [15:0]                 token_length,
    output logic                        last_of_run
);
    logic [1:0] idx_reg, idx_next;
    logic valid_reg;
    logic [TW-1:0] tok_reg;
    logic last_reg;
    logic take;
    logic [TW-1:0] cur;

    assign take = nonempty && (!valid_reg || ready);
    assign cur = g_tok[idx_reg*TW +: TW];
    assign idx_next = (idx_reg + 2'd1 == g_n[1:0] || g_n == 3'd3 && idx_reg == 2'd2)
                      ? 2'd0 : idx_reg + 2'd1;
    assign pop = take && (idx_next == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                idx_reg <= idx_next;
            end
            else if (ready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= cur;
            last_reg <= (idx_next == 2'd0);
        end
    end

    assign valid = valid_reg;
    assign {token_kind, type_code, int_value, fraction_value, fraction_digits,
            start_offset, token_length} = tok_reg;
    assign last_of_run = last_reg;
endmodule
`default_nettype wire

// ----- design/source_text_lexer.sv -----
// Source text lexer top level.
// Takes one source byte per cycle (in_valid/in_ready) and emits 0 to 3 tokens per
// byte, one token per cycle on the output while out_ready is high. The front
// updates the lexing state for each accepted byte; token groups wait in a 4-entry
// queue, so input keeps flowing as long as the output drains at least one token
// per byte on average. The tokens of a byte leave one by one; the drain sets the rate.
`default_nettype none
module source_text_lexer
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            char_code,
    input  wire logic                  end_of_source,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [4:0]                 token_kind,
    output logic [1:0]                 type_code,
    output logic [VALUE_BITS-1:0]      int_value,
    output logic [VALUE_BITS-1:0]      fraction_value,
    output logic [7:0]                 fraction_digits,
    output logic [OFFSET_BITS-1:0]     start_offset,
    output logic [15:0]                token_length,
    output logic                       last_of_run
);
    localparam int TW = 5 + 2 + 2*VALUE_BITS + 8 + OFFSET_BITS + 16;
    localparam int GW = 3 + 3*TW;

    logic step, full, nonempty, pop;
    logic [2:0] n_tok;
    logic [2:0][4:0] t_kind;
    logic [2:0][1:0] t_type;
    logic [2:0][VALUE_BITS-1:0] t_iv, t_fv;
    logic [2:0][7:0] t_fd;
    logic [2:0][OFFSET_BITS-1:0] t_start;
    logic [2:0][15:0] t_len;
    logic [GW-1:0] wdata, rdata;

    assign in_ready = !full;
    assign step = in_valid && in_ready;

    stl_front #(.OFFSET_BITS(OFFSET_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .clk, .rst_n, .step, .c(char_code), .last(end_of_source),
        .n_tok, .t_kind, .t_type, .t_iv, .t_fv, .t_fd, .t_start, .t_len
    );

    always_comb
    begin
        wdata[GW-1 -: 3] = n_tok;
        for (int i = 0; i < 3; i++)
            wdata[i*TW +: TW] = {t_kind[i], t_type[i], t_iv[i], t_fv[i], t_fd[i],
                                 t_start[i], t_len[i]};
    end

    stl_queue #(.W(GW), .DEPTH_LOG(2)) u_queue (
        .clk, .rst_n, .push(step && n_tok != 3'd0), .wdata, .full,
        .pop, .nonempty, .rdata
    );

    stl_back #(.OFFSET_BITS(OFFSET_BITS), .VALUE_BITS(VALUE_BITS), .TW(TW)) u_back (
        .clk, .rst_n, .nonempty, .g_n(rdata[GW-1 -: 3]), .g_tok(rdata[3*TW-1:0]),
        .pop, .valid(out_valid), .ready(out_ready), .token_kind, .type_code,
        .int_value, .fraction_value, .fraction_digits, .start_offset,
        .token_length, .last_of_run
    );
endmodule
`default_nettype wire

// ----- design/stl_checker.sv -----
// Port-level checker for the source text lexer, bound to the top level.
`default_nettype none
`include "source_text_lexer_macros.svh"
module stl_checker
    import stl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [4:0] token_kind,
    input wire logic [15:0] token_length,
    input wire logic       last_of_run
);
    logic is_eof;

    assign is_eof = out_valid && token_kind == K_EOF;

    `STL_ASSERT(a_kind_range, out_valid |-> token_kind <= K_ERROR, "bad token kind")
    `STL_ASSERT(a_eof_last, is_eof |-> last_of_run && token_length == '0, "eof not last")
    `STL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(token_kind), "output dropped")
    `STL_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid, "request dropped")
    `STL_ASSERT_NORST(a_reset_quiet, !rst_n |=> !out_valid, "valid in reset")
endmodule
bind source_text_lexer stl_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .token_kind, .token_length, .last_of_run
);
`default_nettype wire
